[rtl/core/rsrd_pkg.sv]
// Shared types, constants and helper functions of the run-length sprite row decoder.
`default_nettype none
package rsrd_pkg;

  localparam int DIM_BITS      = 11;
  localparam int COORD_BITS    = 16;
  localparam int CNT_BITS      = 16;
  localparam int RUN_BITS      = 7;
  localparam int ADDR_BITS     = 20;
  localparam int BYTE_BITS     = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int PROD_BITS     = COORD_BITS + 1 + DIM_BITS;

  localparam logic [DIM_BITS-1:0]  MAX_DIM   = 11'd1024;
  localparam logic [RUN_BITS-1:0]  MAX_RUN   = 7'd64;
  localparam logic [BYTE_BITS-1:0] MASK_SKIP = 8'h01;
  localparam logic [BYTE_BITS-1:0] MASK_REP  = 8'h02;

  localparam logic [DIM_BITS-1:0]  PITCH_RST = 11'd1;
  localparam logic [BYTE_BITS-1:0] TIDX_RST  = 8'd9;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE   = 3'd0,
    CFG_WIDTH  = 3'd1,
    CFG_HEIGHT = 3'd2,
    CFG_PITCH  = 3'd3,
    CFG_SX     = 3'd4,
    CFG_SY     = 3'd5,
    CFG_TIDX   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_CNT_LO  = 3'd0,
    PH_CNT_HI  = 3'd1,
    PH_MASK    = 3'd2,
    PH_REPEAT  = 3'd3,
    PH_LITERAL = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic decode;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic starts_run;
    logic run_last;
  } dp_status_t;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/rsrd_ctrl.sv]
// Controller state machine: sequences byte capture, decode and repeat-run emission.
`default_nettype none
module rsrd_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  rsrd_pkg::dp_status_t status,
  output rsrd_pkg::dp_cmd_t    cmd
);

  rsrd_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsrd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsrd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rsrd_pkg::ST_DECODE;
      end
      rsrd_pkg::ST_DECODE: begin
        if (status.slot_free) begin
          state_nxt = status.starts_run ? rsrd_pkg::ST_RUN : rsrd_pkg::ST_IDLE;
        end
      end
      rsrd_pkg::ST_RUN: begin
        if (status.slot_free && status.run_last) state_nxt = rsrd_pkg::ST_IDLE;
      end
      default: state_nxt = rsrd_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      rsrd_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rsrd_pkg::ST_DECODE: cmd.decode = status.slot_free;
      rsrd_pkg::ST_RUN:    cmd.step   = status.slot_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/rsrd_datapath.sv]
// Datapath: configuration registers, packet parser state, address arithmetic and result register.
`default_nettype none
module rsrd_datapath (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  rsrd_pkg::dp_cmd_t                      cmd,
  output rsrd_pkg::dp_status_t                   status,
  input  wire  [rsrd_pkg::BYTE_BITS-1:0]         in_data_byte,
  input  wire                                    cfg_write_en,
  input  wire  [rsrd_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire  [rsrd_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic                                   out_write_enable,
  output logic [rsrd_pkg::ADDR_BITS-1:0]         out_write_address,
  output logic [rsrd_pkg::BYTE_BITS-1:0]         out_pixel_value,
  output logic                                   out_beyond_pitch,
  output logic                                   out_last_of_run,
  output logic                                   out_frame_done
);

  localparam int DB = rsrd_pkg::DIM_BITS;
  localparam int CB = rsrd_pkg::COORD_BITS;
  localparam int NB = rsrd_pkg::CNT_BITS;
  localparam int RB = rsrd_pkg::RUN_BITS;
  localparam int AB = rsrd_pkg::ADDR_BITS;
  localparam int BB = rsrd_pkg::BYTE_BITS;

  // Configuration registers.
  logic          mode_r;
  logic [DB-1:0] fwidth_r, fheight_r, pitch_r;
  logic [CB-1:0] sx_r, sy_r;
  logic [BB-1:0] tidx_r;

  // Parser state.
  logic [DB-1:0]   row_r, row_nxt;
  logic [CB-1:0]   col_r, col_nxt;
  rsrd_pkg::phase_t phase_r, phase_nxt;
  logic [NB-1:0]   cnt_r, cnt_nxt;
  logic [NB-1:0]   used_r, used_nxt;
  logic [RB-1:0]   lit_r, lit_nxt;
  logic [RB-1:0]   rep_r, rep_nxt;
  logic [RB-1:0]   run_r, run_nxt;
  logic [BB-1:0]   byte_r;
  logic [AB-1:0]   row_base_r;

  // Result register.
  logic          out_valid_r;
  logic          out_we_r, out_beyond_r, out_last_r, out_done_r;
  logic [AB-1:0] out_addr_r;
  logic [BB-1:0] out_pix_r;

  // Combinational helpers.
  logic                          cfg_hit;
  logic [DB-1:0]                 cfg_dim;
  logic                          frame_active;
  logic [CB:0]                   ysum;
  logic [rsrd_pkg::PROD_BITS-1:0] prod;
  logic [CB:0]                   col_sum;
  logic [AB-1:0]                 pix_addr;
  logic                          pix_beyond;
  logic [BB-1:0]                 mapped;
  logic [CB-1:0]                 col_inc;
  logic [NB-1:0]                 used_inc;
  logic [NB-1:0]                 cnt_full;
  logic [RB-1:0]                 pkt_len;
  logic [RB-1:0]                 lit_dec;
  logic                          emit, e_we, e_last, e_done;
  logic [BB-1:0]                 e_pix;
  logic                          pkt_done, end_row;

  assign cfg_hit = cfg_write_en && (cfg_index <= rsrd_pkg::CFG_TIDX);
  assign cfg_dim = rsrd_pkg::clamp_dim(cfg_data[DB-1:0]);

  assign frame_active = (row_r < fheight_r);

  // Row base address: (start_y + row) * pitch, kept one register behind the row.
  assign ysum = {1'b0, sy_r} + {{(CB+1-DB){1'b0}}, row_r};
  assign prod = ysum * pitch_r;

  assign col_sum    = {1'b0, sx_r} + {1'b0, col_r};
  assign pix_addr   = row_base_r + {{(AB-CB-1){1'b0}}, col_sum};
  assign pix_beyond = (col_sum >= {{(CB+1-DB){1'b0}}, pitch_r});
  assign mapped     = (byte_r == tidx_r) ? '0 : byte_r;

  assign col_inc  = col_r + 1'b1;
  assign used_inc = (used_r == {NB{1'b1}}) ? used_r : used_r + 1'b1;
  assign cnt_full = {cnt_r[NB-1:BB] | byte_r, cnt_r[BB-1:0]};
  assign pkt_len  = {1'b0, byte_r[BB-1:2]} + 1'b1;
  assign lit_dec  = (lit_r == '0) ? '0 : lit_r - 1'b1;

  assign status.slot_free  = !out_valid_r || out_ready;
  assign status.starts_run = frame_active && mode_r && (phase_r == rsrd_pkg::PH_REPEAT);
  assign status.run_last   = (run_r == {{(RB-1){1'b0}}, 1'b1});

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    used_nxt  = used_r;
    lit_nxt   = lit_r;
    rep_nxt   = rep_r;
    run_nxt   = run_r;
    emit      = 1'b0;
    e_we      = 1'b0;
    e_pix     = '0;
    e_last    = 1'b0;
    pkt_done  = 1'b0;
    end_row   = 1'b0;

    if (cmd.decode) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (frame_active) begin
        if (!mode_r) begin
          if (fwidth_r == '0) begin
            row_nxt = fheight_r;
          end else begin
            e_we    = 1'b1;
            e_pix   = byte_r;
            col_nxt = col_inc;
            if (col_inc >= {{(CB-DB){1'b0}}, fwidth_r}) end_row = 1'b1;
          end
        end else begin
          unique case (phase_r)
            rsrd_pkg::PH_CNT_LO: begin
              cnt_nxt   = {{(NB-BB){1'b0}}, byte_r};
              phase_nxt = rsrd_pkg::PH_CNT_HI;
            end
            rsrd_pkg::PH_CNT_HI: begin
              cnt_nxt  = cnt_full;
              used_nxt = '0;
              col_nxt  = '0;
              if (cnt_full == '0) end_row = 1'b1;
              else phase_nxt = rsrd_pkg::PH_MASK;
            end
            rsrd_pkg::PH_MASK: begin
              used_nxt = used_inc;
              if ((byte_r & rsrd_pkg::MASK_SKIP) != '0) begin
                col_nxt  = col_r + {{(CB-BB+1){1'b0}}, byte_r[BB-1:1]};
                pkt_done = 1'b1;
              end else if ((byte_r & rsrd_pkg::MASK_REP) != '0) begin
                rep_nxt   = pkt_len;
                phase_nxt = rsrd_pkg::PH_REPEAT;
              end else begin
                lit_nxt   = pkt_len;
                phase_nxt = rsrd_pkg::PH_LITERAL;
              end
            end
            rsrd_pkg::PH_REPEAT: begin
              // The run itself is emitted one pixel per cycle in the run state, while the result slot is free.
              emit   = 1'b0;
              e_last = 1'b0;
              run_nxt = (rep_r == '0 || rep_r > rsrd_pkg::MAX_RUN) ?
                        {{(RB-1){1'b0}}, 1'b1} : rep_r;
            end
            rsrd_pkg::PH_LITERAL: begin
              e_we     = 1'b1;
              e_pix    = mapped;
              col_nxt  = col_inc;
              used_nxt = used_inc;
              lit_nxt  = lit_dec;
              if (lit_dec == '0) pkt_done = 1'b1;
            end
            default: phase_nxt = rsrd_pkg::PH_CNT_LO;
          endcase
        end
      end
    end else if (cmd.step) begin
      emit    = 1'b1;
      e_we    = 1'b1;
      e_pix   = mapped;
      col_nxt = col_inc;
      run_nxt = run_r - 1'b1;
      if (status.run_last) begin
        e_last   = 1'b1;
        rep_nxt  = '0;
        used_nxt = used_inc;
        pkt_done = 1'b1;
      end
    end

    if (pkt_done) begin
      if (used_inc >= cnt_r) end_row = 1'b1;
      else phase_nxt = rsrd_pkg::PH_MASK;
    end
    if (end_row) begin
      row_nxt   = row_r + 1'b1;
      col_nxt   = '0;
      phase_nxt = rsrd_pkg::PH_CNT_LO;
    end
    e_done = e_last && (row_nxt >= fheight_r);
  end

  // Configuration and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      fwidth_r  <= '0;
      fheight_r <= '0;
      pitch_r   <= rsrd_pkg::PITCH_RST;
      sx_r      <= '0;
      sy_r      <= '0;
      tidx_r    <= rsrd_pkg::TIDX_RST;
      row_r     <= '0;
      col_r     <= '0;
      phase_r   <= rsrd_pkg::PH_CNT_LO;
      cnt_r     <= '0;
      used_r    <= '0;
      lit_r     <= '0;
      rep_r     <= '0;
      run_r     <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        rsrd_pkg::CFG_MODE:   mode_r    <= cfg_data[0];
        rsrd_pkg::CFG_WIDTH:  fwidth_r  <= cfg_dim;
        rsrd_pkg::CFG_HEIGHT: fheight_r <= cfg_dim;
        rsrd_pkg::CFG_PITCH:  pitch_r   <= cfg_dim;
        rsrd_pkg::CFG_SX:     sx_r      <= cfg_data[CB-1:0];
        rsrd_pkg::CFG_SY:     sy_r      <= cfg_data[CB-1:0];
        default:              tidx_r    <= cfg_data[BB-1:0];
      endcase
      row_r   <= '0;
      col_r   <= '0;
      phase_r <= rsrd_pkg::PH_CNT_LO;
      cnt_r   <= '0;
      used_r  <= '0;
      lit_r   <= '0;
      rep_r   <= '0;
      run_r   <= '0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      used_r  <= used_nxt;
      lit_r   <= lit_nxt;
      rep_r   <= rep_nxt;
      run_r   <= run_nxt;
    end
  end

  // Captured byte and row base address.
  always_ff @(posedge clk) begin
    if (cmd.accept) byte_r <= in_data_byte;
    row_base_r <= prod[AB-1:0];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_we_r     <= e_we;
      out_addr_r   <= e_we ? pix_addr : '0;
      out_pix_r    <= e_pix;
      out_beyond_r <= e_we && pix_beyond;
      out_last_r   <= e_last;
      out_done_r   <= e_done;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_addr_r;
  assign out_pixel_value   = out_pix_r;
  assign out_beyond_pitch  = out_beyond_r;
  assign out_last_of_run   = out_last_r;
  assign out_frame_done    = out_done_r;

endmodule
`default_nettype wire

[rtl/core/rle_sprite_row_decoder.sv]
// Top level of the run-length sprite row decoder: controller plus datapath.
// The first result of a byte is registered in the result register after the byte is captured
// and decoded; the pixel byte of a repeat run goes through decode and then the run state first.
// A new byte is not taken before the last one is through: a repeat-run byte of n pixels stays
// in the run state, where the single result register takes one pixel write per cycle while free.
// Reset: rst_n is synchronous and active low; it returns the configuration, parser and controller
// registers to their reset values, restarts the frame and empties the result register.
`default_nettype none
module rle_sprite_row_decoder (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire  [rsrd_pkg::BYTE_BITS-1:0]      in_data_byte,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_write_enable,
  output logic [rsrd_pkg::ADDR_BITS-1:0]      out_write_address,
  output logic [rsrd_pkg::BYTE_BITS-1:0]      out_pixel_value,
  output logic                                out_beyond_pitch,
  output logic                                out_last_of_run,
  output logic                                out_frame_done,
  input  wire                                 cfg_write_en,
  input  wire  [rsrd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire  [rsrd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // The controller accepts one byte per input transaction, then lets the datapath
  // decode it. Every decode produces exactly one result transaction, except the byte
  // that follows a repeat mask: it starts a run, and the controller then steps the
  // datapath once per free result slot until the last pixel of the run is written.
  // The datapath holds all configuration and parsing state; a configuration write
  // restarts the frame. The row base address is a registered multiply that always
  // follows the current row, ready before the next byte can reach decode.
  rsrd_pkg::dp_cmd_t    cmd;
  rsrd_pkg::dp_status_t status;

  rsrd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rsrd_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_data_byte      (in_data_byte),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_pixel_value   (out_pixel_value),
    .out_beyond_pitch  (out_beyond_pitch),
    .out_last_of_run   (out_last_of_run),
    .out_frame_done    (out_frame_done)
  );

endmodule
`default_nettype wire
